FILE: rtl/pip_pkg.sv
// Shared constants and types for the point-in-polygon test block.
package pip_pkg;

  localparam int MaxVertices = 16;
  localparam int AddrW       = $clog2(MaxVertices);
  localparam int NumW        = $clog2(MaxVertices + 1);
  localparam int CoordW      = 16;
  localparam int DiffW       = CoordW + 1;
  localparam int ProdW       = 2 * DiffW;
  localparam int CountW      = 5;
  localparam int SlotW       = 4;
  localparam int VertW       = 2 * CoordW;

  localparam logic OpWrite = 1'b0;
  localparam logic OpTest  = 1'b1;

  // Step strobes from the sequencer to the shared edge unit
  typedef struct packed {
    logic mul_lhs;  // (tx - xi) * (yj - yi)
    logic mul_rhs;  // (xj - xi) * (ty - yi), plus straddle test
  } pip_ctrl_t;

endpackage

FILE: rtl/point_in_polygon_test.sv
// Top level of the point-in-polygon test: vertex store, sequencer and edge unit.
//
// Usage
//   Requests enter on start/busy: a request is taken at a clock edge where start
//   is high and busy is low. operation_i selects a vertex write or a point test.
//   A vertex write stores point_x_i/point_y_i in slot vertex_index_i and gives
//   no result; busy stays low, so writes may follow back to back.
//   A point test gives exactly one result: res_valid_o is high for one cycle with
//   inside_res_o (even-odd crossing rule). The receiver cannot stall; the result
//   is gone after that cycle. vertex_count is set by the user through
//   cfg_we_i/cfg_data_i while the block is idle; the block does not enforce it.
//   Values above the store depth are treated as the full store.
// Sequence
//   For n vertices in use (n >= 1) the test fetches the closing vertex from the
//   store (StLoadJ), walks every edge in use through StEdgeA and StEdgeB on one shared
//   17x17 multiplier, then finishes the last compare (StFlush). The result
//   appears as busy falls, so the next request can be taken in that same cycle.
//   A test with n = 0 answers 0 on the next cycle.
// Reset
//   rst_ni clears the sequencer, the result strobe and vertex_count. The vertex
//   store is not cleared; every vertex in use must be written before a test.
module point_in_polygon_test (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic [pip_pkg::SlotW-1:0]    vertex_index_i,
  input  logic signed [15:0]           point_x_i,
  input  logic signed [15:0]           point_y_i,
  input  logic                         cfg_we_i,
  input  logic [pip_pkg::CountW-1:0]   cfg_data_i,
  output logic                         res_valid_o,
  output logic                         inside_res_o
);
  import pip_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StLoadJ,
    StEdgeA,
    StEdgeB,
    StFlush
  } state_e;

  state_e                   state_q;
  logic [CountW-1:0]        count_q;
  logic [AddrW-1:0]         idx_q, last_q;
  logic signed [CoordW-1:0] tx_q, ty_q, vj_x_q, vj_y_q;
  logic                     inside_q;
  logic                     res_valid_q, res_q;

  logic                     accept, wr_accept, test_accept;
  logic [NumW-1:0]          n_sat;
  logic [AddrW-1:0]         n_last;
  logic                     ram_we, ram_re;
  logic [AddrW-1:0]         ram_raddr;
  logic [VertW-1:0]         ram_rdata;
  logic signed [CoordW-1:0] vi_x, vi_y;
  pip_ctrl_t                ctrl;
  logic                     toggle;

  assign busy        = (state_q != StIdle);
  assign accept      = start && !busy;
  assign wr_accept   = accept && (operation_i == OpWrite);
  assign test_accept = accept && (operation_i == OpTest);

  // Count saturates at the store depth
  assign n_sat  = (int'(count_q) > MaxVertices) ? NumW'(MaxVertices) : NumW'(count_q);
  assign n_last = AddrW'(n_sat - NumW'(1));

  // Out-of-range slots are dropped
  assign ram_we = wr_accept && (int'(vertex_index_i) < MaxVertices);

  pip_ram #(
    .Width (VertW),
    .Depth (MaxVertices)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(vertex_index_i)),
    .wdata_i ({point_x_i, point_y_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign vi_x = ram_rdata[VertW-1:CoordW];
  assign vi_y = ram_rdata[CoordW-1:0];

  // Store read address: closing vertex first, then 0..n-1
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_q + AddrW'(1);
    unique case (state_q)
      StIdle: begin
        ram_re    = test_accept && (n_sat != '0);
        ram_raddr = n_last;
      end
      StLoadJ: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      StEdgeB: begin
        ram_re    = (idx_q != last_q);
        ram_raddr = idx_q + AddrW'(1);
      end
      StEdgeA, StFlush: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  assign ctrl = pip_ctrl_t'{mul_lhs: (state_q == StEdgeA), mul_rhs: (state_q == StEdgeB)};

  pip_edge_unit u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .vi_x_i   (vi_x),
    .vi_y_i   (vi_y),
    .vj_x_i   (vj_x_q),
    .vj_y_i   (vj_y_q),
    .tx_i     (tx_q),
    .ty_i     (ty_q),
    .toggle_o (toggle)
  );

  // Sequencer, running flag and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      last_q      <= '0;
      inside_q    <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= 1'b0;
      tx_q        <= '0;
      ty_q        <= '0;
      vj_x_q      <= '0;
      vj_y_q      <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      if (toggle) begin
        inside_q <= !inside_q;
      end
      unique case (state_q)
        StIdle: begin
          if (test_accept) begin
            tx_q     <= point_x_i;
            ty_q     <= point_y_i;
            idx_q    <= '0;
            last_q   <= n_last;
            inside_q <= 1'b0;
            if (n_sat == '0) begin
              res_valid_q <= 1'b1;
              res_q       <= 1'b0;
            end else begin
              state_q <= StLoadJ;
            end
          end
        end
        StLoadJ: begin
          vj_x_q  <= vi_x;
          vj_y_q  <= vi_y;
          state_q <= StEdgeA;
        end
        StEdgeA: begin
          state_q <= StEdgeB;
        end
        StEdgeB: begin
          // current vertex becomes the previous one for the next edge
          vj_x_q <= vi_x;
          vj_y_q <= vi_y;
          if (idx_q == last_q) begin
            state_q <= StFlush;
          end else begin
            idx_q   <= idx_q + AddrW'(1);
            state_q <= StEdgeA;
          end
        end
        StFlush: begin
          res_valid_q <= 1'b1;
          res_q       <= inside_q ^ toggle;
          state_q     <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign res_valid_o  = res_valid_q;
  assign inside_res_o = res_q;

  // A result only follows the last edge or an empty-polygon test
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == StFlush) || $past(test_accept))
    else $error("result strobe without a finished test");

  // Edge index never runs past the last vertex in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEdgeA || state_q == StEdgeB) |-> (idx_q <= last_q))
    else $error("edge index beyond vertex count");

  // A non-empty test starts by fetching the closing vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (test_accept && n_sat != '0) |=> (state_q == StLoadJ) && busy)
    else $error("test did not start the edge walk");

  // Store is never written while an edge walk is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !ram_we)
    else $error("vertex write during a test");

endmodule

FILE: rtl/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pip_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pip_edge_unit.sv
// Shared edge unit: one signed multiplier used twice per edge, then an exact compare.
module pip_edge_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pip_pkg::pip_ctrl_t        ctrl_i,
  input  logic signed [15:0]        vi_x_i,
  input  logic signed [15:0]        vi_y_i,
  input  logic signed [15:0]        vj_x_i,
  input  logic signed [15:0]        vj_y_i,
  input  logic signed [15:0]        tx_i,
  input  logic signed [15:0]        ty_i,
  output logic                      toggle_o
);
  import pip_pkg::*;

  logic signed [DiffW-1:0] op_a, op_b;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] lhs_q, lhs_d, rhs_q, rhs_d;
  logic                    straddle_q, straddle_d;
  logic                    dy_pos_q, dy_pos_d;
  logic                    pend_q;

  function automatic logic signed [DiffW-1:0] sub_ext(logic signed [CoordW-1:0] a,
                                                      logic signed [CoordW-1:0] b);
    return DiffW'(a) - DiffW'(b);
  endfunction

  // Operand select for the single multiplier
  always_comb begin
    if (ctrl_i.mul_rhs) begin
      op_a = sub_ext(vj_x_i, vi_x_i);
      op_b = sub_ext(ty_i, vi_y_i);
    end else begin
      op_a = sub_ext(tx_i, vi_x_i);
      op_b = sub_ext(vj_y_i, vi_y_i);
    end
  end

  assign prod = ProdW'(op_a) * ProdW'(op_b);

  always_comb begin
    lhs_d      = ctrl_i.mul_lhs ? prod : lhs_q;
    rhs_d      = ctrl_i.mul_rhs ? prod : rhs_q;
    straddle_d = ctrl_i.mul_rhs ? ((vi_y_i > ty_i) != (vj_y_i > ty_i)) : straddle_q;
    dy_pos_d   = ctrl_i.mul_rhs ? (vj_y_i > vi_y_i) : dy_pos_q;
  end

  always_ff @(posedge clk_i) begin
    lhs_q      <= lhs_d;
    rhs_q      <= rhs_d;
    straddle_q <= straddle_d;
    dy_pos_q   <= dy_pos_d;
  end

  // Compare runs the cycle after the second product, alongside the next edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= ctrl_i.mul_rhs;
    end
  end

  // Sign of dy flips the sense; a flat edge never straddles
  assign toggle_o = pend_q && straddle_q && (dy_pos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q));

endmodule
